### rtl/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// shared constants, payload structs, opcodes and controller types for the
// uart receive and transmit ring buffer block
// ----------------------------------------------------------------------------
package urb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int FILL_W   = 6;

  typedef enum logic [2:0] {
    OP_RX_BYTE   = 3'd0,
    OP_LINE_RDY  = 3'd1,
    OP_HOST_RD   = 3'd2,
    OP_HOST_WR   = 3'd3,
    OP_QUERY     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       parity_error;
    logic       line_ready;
  } urb_in_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              read_empty;
    logic [FILL_W-1:0] fill_count;
    logic [7:0]        line_byte;
    logic              line_valid;
    logic              irq_enable;
    logic              write_accepted;
    logic              rx_dropped;
  } urb_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rx_push;
    logic rx_pop;
    logic tx_push;
    logic tx_pop;
    logic direct;
    logic irq_set;
    logic irq_clr;
    logic drop;
    logic rd_empty;
    logic accept;
    logic respond;
  } urb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       perr;
    logic       ready;
    logic       rx_full;
    logic       rx_empty;
    logic       tx_full;
    logic       tx_empty;
    logic       tx_one;
  } urb_stat_t;

endpackage

### rtl/urb_ram.sv
// ----------------------------------------------------------------------------
// urb_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/urb_ctrl.sv
// ----------------------------------------------------------------------------
// urb_ctrl
// sequencer: capture, execute, respond; decides queue actions from status
// ----------------------------------------------------------------------------
module urb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  urb_pkg::urb_stat_t stat,
  output urb_pkg::urb_cmd_t  cmd
);
  import urb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: begin
        case (op_t'(stat.op))
          OP_RX_BYTE: begin
            if (stat.perr || stat.rx_full) cmd.drop = 1'b1;
            else cmd.rx_push = 1'b1;
          end
          OP_LINE_RDY: begin
            cmd.tx_pop  = !stat.tx_empty;
            cmd.irq_clr = stat.tx_empty || stat.tx_one;
          end
          OP_HOST_RD: begin
            if (stat.rx_empty) cmd.rd_empty = 1'b1;
            else cmd.rx_pop = 1'b1;
          end
          OP_HOST_WR: begin
            if (stat.tx_empty && stat.ready) begin
              cmd.direct = 1'b1;
              cmd.accept = 1'b1;
            end else if (!stat.tx_full) begin
              cmd.tx_push = 1'b1;
              cmd.irq_set = 1'b1;
              cmd.accept  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_RESP: cmd.respond = 1'b1;
      default: ;
    endcase
  end

  a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> cmd.respond)
    else $error("response did not follow execute");

endmodule

### rtl/urb_dp.sv
// ----------------------------------------------------------------------------
// urb_dp
// queue pointers, both byte stores, interrupt enable and result assembly
// ----------------------------------------------------------------------------
module urb_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  urb_pkg::urb_in_t   in_data,
  input  urb_pkg::urb_cmd_t  cmd,
  output urb_pkg::urb_stat_t stat,
  output urb_pkg::urb_out_t  out_data
);
  import urb_pkg::*;

  logic [RX_AW-1:0] rx_head_r, rx_tail_r, rx_head_inc, rx_tail_inc;
  logic [TX_AW-1:0] tx_head_r, tx_tail_r, tx_head_inc, tx_tail_inc;
  logic             irq_r;
  urb_in_t          item_r;

  logic rd_pop_r, tx_pop_r, direct_r, rd_empty_r, accept_r, drop_r;
  logic [7:0] rx_q, tx_q;
  logic [RX_AW:0] fill;

  assign rx_head_inc = (rx_head_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_r + RX_AW'(1);
  assign rx_tail_inc = (rx_tail_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_r + RX_AW'(1);
  assign tx_head_inc = (tx_head_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_r + TX_AW'(1);
  assign tx_tail_inc = (tx_tail_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_r + TX_AW'(1);

  always_comb begin
    stat.op       = item_r.operation;
    stat.perr     = item_r.parity_error;
    stat.ready    = item_r.line_ready;
    stat.rx_full  = (rx_head_inc == rx_tail_r);
    stat.rx_empty = (rx_head_r == rx_tail_r);
    stat.tx_full  = (tx_head_inc == tx_tail_r);
    stat.tx_empty = (tx_head_r == tx_tail_r);
    stat.tx_one   = (tx_tail_inc == tx_head_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r <= '0;
      rx_tail_r <= '0;
      tx_head_r <= '0;
      tx_tail_r <= '0;
      irq_r     <= 1'b0;
    end else begin
      if (cmd.rx_push) rx_head_r <= rx_head_inc;
      if (cmd.rx_pop)  rx_tail_r <= rx_tail_inc;
      if (cmd.tx_push) tx_head_r <= tx_head_inc;
      if (cmd.tx_pop)  tx_tail_r <= tx_tail_inc;
      if (cmd.irq_set) irq_r <= 1'b1;
      else if (cmd.irq_clr) irq_r <= 1'b0;
    end
  end

  // captured item and per-step flags, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    rd_pop_r   <= cmd.rx_pop;
    tx_pop_r   <= cmd.tx_pop;
    direct_r   <= cmd.direct;
    rd_empty_r <= cmd.rd_empty;
    accept_r   <= cmd.accept;
    drop_r     <= cmd.drop;
  end

  urb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (cmd.rx_push),
    .waddr (rx_head_r),
    .wdata (item_r.data_byte),
    .re    (cmd.rx_pop),
    .raddr (rx_tail_r),
    .rdata (rx_q)
  );

  urb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (cmd.tx_push),
    .waddr (tx_head_r),
    .wdata (item_r.data_byte),
    .re    (cmd.tx_pop),
    .raddr (tx_tail_r),
    .rdata (tx_q)
  );

  always_comb begin
    if (rx_head_r >= rx_tail_r) begin
      fill = {1'b0, rx_head_r} - {1'b0, rx_tail_r};
    end else begin
      fill = {1'b0, rx_head_r} + (RX_AW + 1)'(RX_DEPTH) - {1'b0, rx_tail_r};
    end
  end

  always_comb begin
    out_data.read_data      = rd_pop_r ? rx_q : 8'd0;
    out_data.read_empty     = rd_empty_r;
    out_data.fill_count     = FILL_W'(fill);
    out_data.line_byte      = tx_pop_r ? tx_q : (direct_r ? item_r.data_byte : 8'd0);
    out_data.line_valid     = tx_pop_r || direct_r;
    out_data.irq_enable     = irq_r;
    out_data.write_accepted = accept_r;
    out_data.rx_dropped     = drop_r;
  end

  a_rx_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rx_push |-> !stat.rx_full && !cmd.rx_pop)
    else $error("receive push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rx_pop |-> !stat.rx_empty) and (cmd.tx_pop |-> !stat.tx_empty))
    else $error("pop from empty queue");

  a_irq_off_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.tx_empty |-> !irq_r)
    else $error("transmit irq enabled with empty queue");

endmodule

### rtl/uart_rx_tx_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// receive and transmit byte ring buffers between a uart line and a host
// ----------------------------------------------------------------------------
// An event is taken when start is high while busy is low; busy then stays
// high through the execute and respond steps, and the block takes no new
// event until it is back in idle. The three steps are capture, execute
// (pointer compares and at most one store access) and respond, the last set
// by the registered read of the byte stores. The result appears on out_data
// for exactly one cycle with out_valid high, in the respond step that follows
// execute; the receiver cannot stall and must take it in that cycle. Each
// queue holds at most depth-1 bytes. The stores are not cleared after reset.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  urb_pkg::urb_in_t  in_data,
  output logic              out_valid,
  output urb_pkg::urb_out_t out_data
);
  import urb_pkg::*;

  // command and status between sequencer and datapath
  urb_cmd_t  cmd;
  urb_stat_t stat;

  // sequencer decides queue actions from the captured event
  urb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // pointers, stores and result assembly
  urb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // result strobe, one cycle per transfer
  assign out_valid = cmd.respond;

endmodule
